FILE: rtl/mfcw_pkg.sv
// ----------------------------------------------------------------------------
// mfcw_pkg
// Shared types and constants of the clipped-window median filter.
// ----------------------------------------------------------------------------
package mfcw_pkg;

	localparam int PIX_W        = 8;
	localparam int CNT_W        = 24;
	localparam int CFG_W        = 13;
	localparam int IDX_W        = 2;
	localparam int HEIGHT_LIMIT = 4096;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_HALF   = 2'd2;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_TAIL,
		ST_START,
		ST_SELECT,
		ST_EMIT,
		ST_RECALC
	} state_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] value;
	} rank_stat_t;

endpackage

FILE: rtl/mfcw_store.sv
// ----------------------------------------------------------------------------
// mfcw_store
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfcw_store #(
	parameter int DEPTH = 7168,
	parameter int AW    = 13
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [mfcw_pkg::PIX_W-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [mfcw_pkg::PIX_W-1:0] rd_data
);
	import mfcw_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/mfcw_rank.sv
// ----------------------------------------------------------------------------
// mfcw_rank
// Radix select of the element of rank n/2, one bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mfcw_rank #(
	parameter int WIN_MAX = 49,
	parameter int NW      = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [NW-1:0]                         n,
	input  logic [WIN_MAX-1:0][mfcw_pkg::PIX_W-1:0] win,
	output mfcw_pkg::rank_stat_t                  stat
);
	import mfcw_pkg::*;

	localparam int BW = $clog2(PIX_W);

	logic               busy_q;
	logic [BW-1:0]      bit_q;
	logic [NW-1:0]      rank_q;
	logic [WIN_MAX-1:0] live_q;
	logic [PIX_W-1:0]   val_q;
	logic               done_q;
	logic [WIN_MAX-1:0] ones;
	logic [NW-1:0]      cnt0;
	logic               pick_one;

	always_comb begin
		for (int i = 0; i < WIN_MAX; i++) begin
			ones[i] = win[i][bit_q];
		end
		cnt0     = NW'($countones(live_q & ~ones));
		pick_one = (rank_q >= cnt0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(PIX_W - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rank_q <= n >> 1;
			for (int i = 0; i < WIN_MAX; i++) begin
				live_q[i] <= (NW'(i) < n);
			end
		end else if (busy_q) begin
			val_q[bit_q] <= pick_one;
			if (pick_one) begin
				rank_q <= rank_q - cnt0;
				live_q <= live_q & ones;
			end else begin
				live_q <= live_q & ~ones;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.value = val_q;

endmodule

FILE: rtl/median_filter_clipped_window_core.sv
// ----------------------------------------------------------------------------
// median_filter_clipped_window_core
// Streaming 2-D median over a square window clipped at the frame border.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input words: s_tdata[7:0] is the pixel, s_tuser is the kind
//   (0 = pixel of the frame, 1 = drain tick). m_* carries results:
//   m_tdata[7:0] is the median, m_tlast marks the last pixel of the frame.
//   Registers (width, height, half size) are written through cfg_* while
//   nothing is in flight; after the last write the input is held off
//   while the frame position is re-derived for the new width.
//   Output k of a frame follows input word k+h*W+h.
//   A word that yields no result is taken without holding the input off.
//   A word that yields a result holds the input off until its result is
//   loaded into the output register. It passes through one line-store
//   read per window pixel (at most (2*MAX_HALF+1)^2 of them), the read
//   latency of the store, the start of the selection, bit-by-bit rank
//   selection (eight bits and the done flag) and the load of the output
//   register.
//   Reset clears counters, state and the output valid flag; the line store
//   is not cleared, as every pixel is written before it is read.
//   When the receiver stalls, the finished word is held in the output
//   register and the next input word is still taken; a second result waits
//   until the register frees.
// ----------------------------------------------------------------------------
module median_filter_clipped_window_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HALF  = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
	input  logic                          s_tuser,   // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] pixel_out
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [mfcw_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [mfcw_pkg::CFG_W-1:0]    cfg_data
);
	import mfcw_pkg::*;

	localparam int ROWS    = 2 * MAX_HALF + 1;
	localparam int WIN_MAX = ROWS * ROWS;
	localparam int DEPTH   = ROWS * MAX_WIDTH;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int EWW     = $clog2(MAX_WIDTH + 1);
	localparam int RW      = $clog2(ROWS);
	localparam int HW      = $clog2(MAX_HALF + 1);
	localparam int NW      = $clog2(WIN_MAX + 1);
	localparam int WIW     = $clog2(WIN_MAX);
	localparam int DCW     = $clog2(CNT_W);

	// configuration
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [1:0]  half_q;

	logic [12:0]    w13;
	logic [EWW-1:0] eff_w;
	logic [12:0]    eff_h;
	logic [3:0]     h4;
	logic [HW-1:0]  eff_hf;
	logic [CNT_W-1:0] total, lag;

	// frame counters and positions
	logic [CNT_W-1:0] is_q, og_q;
	logic [CW-1:0]    wcol_q, ocol_q;
	logic [RW-1:0]    wrm_q, orm_q;
	logic [12:0]      orow_q;

	state_t state_q, state_d;

	// window gather
	logic [CW-1:0] gc_q, c0_q, c1_q;
	logic [12:0]   gr_q, r1_q;
	logic [RW-1:0] grm_q;
	logic          rd_v_s1;
	logic [NW-1:0] n_q;
	logic [WIN_MAX-1:0][PIX_W-1:0] win_q;
	logic          gather_end;

	logic             out_v_q, out_l_q;
	logic [PIX_W-1:0] out_d_q;

	rank_stat_t rstat;
	logic [PIX_W-1:0] rd_data;

	// accept-time decode
	logic             acc, fr_clr, in_frame, drop, do_wr, emit;
	logic [CNT_W-1:0] is_b, og_b, is_n;
	logic [CW-1:0]    wcol_b, ocol_b;
	logic [RW-1:0]    wrm_b, orm_b;
	logic [12:0]      orow_b;
	logic [EWW:0]     cx_hi;
	logic [13:0]      ry_hi;
	logic [CW-1:0]    c0_n, c1_n;
	logic [12:0]      r0_n, r1_n;
	logic [RW:0]      dd, rs_n;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic             rd_en, fin;

	// position re-derivation after a register write: both counters are
	// divided by the width, one quotient bit per cycle, MSB first
	logic [DCW-1:0] dv_cnt_q;
	logic [EWW-1:0] is_rem_q, og_rem_q;
	logic [RW-1:0]  is_rm_q, og_rm_q;
	logic [12:0]    og_quo_q;
	logic [EWW:0]   is_t, og_t;
	logic           is_ge, og_ge;
	logic [EWW-1:0] is_rem_n, og_rem_n;
	logic [RW:0]    is_rm_t, og_rm_t;
	logic [RW-1:0]  is_rm_n, og_rm_n;
	logic           dv_end;

	// effective register values, saturated
	always_comb begin
		w13 = {2'b0, width_q};
		if (w13 == '0) w13 = 13'd1;
		else if (w13 > 13'(MAX_WIDTH)) w13 = 13'(MAX_WIDTH);
		eff_w = w13[EWW-1:0];
		eff_h = height_q;
		if (eff_h == '0) eff_h = 13'd1;
		else if (eff_h > 13'(HEIGHT_LIMIT)) eff_h = 13'(HEIGHT_LIMIT);
		h4 = {2'b0, half_q};
		if (h4 > 4'(MAX_HALF)) h4 = 4'(MAX_HALF);
		eff_hf = h4[HW-1:0];
		total  = CNT_W'(eff_w) * CNT_W'(eff_h);
		lag    = CNT_W'(eff_hf) * CNT_W'(eff_w) + CNT_W'(eff_hf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			half_q   <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_HALF:   half_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// hold the input off during a register write so the two never meet
	assign s_tready = (state_q == ST_IDLE) && !cfg_we;
	assign acc      = s_tvalid && s_tready;

	// step decode: restart a finished frame, drop early drains, count items
	always_comb begin
		fr_clr   = (og_q >= total);
		is_b     = fr_clr ? '0 : is_q;
		og_b     = fr_clr ? '0 : og_q;
		wcol_b   = fr_clr ? '0 : wcol_q;
		wrm_b    = fr_clr ? '0 : wrm_q;
		ocol_b   = fr_clr ? '0 : ocol_q;
		orm_b    = fr_clr ? '0 : orm_q;
		orow_b   = fr_clr ? '0 : orow_q;
		in_frame = (is_b < total);
		drop     = in_frame && (s_tuser == ACT_DRAIN);
		do_wr    = in_frame && (s_tuser == ACT_PIXEL);
		is_n     = is_b + 1'b1;
		emit     = !drop && (is_n >= og_b + lag + 1'b1);

		// clipped window bounds of the next output position
		c0_n  = (ocol_b >= CW'(eff_hf)) ? ocol_b - CW'(eff_hf) : '0;
		cx_hi = (EWW+1)'(ocol_b) + (EWW+1)'(eff_hf);
		c1_n  = (cx_hi < (EWW+1)'(eff_w)) ? cx_hi[CW-1:0] : CW'(eff_w - 1'b1);
		r0_n  = (orow_b >= 13'(eff_hf)) ? orow_b - 13'(eff_hf) : '0;
		ry_hi = 14'(orow_b) + 14'(eff_hf);
		r1_n  = (ry_hi < 14'(eff_h)) ? ry_hi[12:0] : eff_h - 1'b1;
		dd    = (RW+1)'(orow_b - r0_n);
		rs_n  = ((RW+1)'(orm_b) >= dd) ? (RW+1)'(orm_b) - dd
		                                : (RW+1)'(orm_b) + (RW+1)'(ROWS) - dd;
	end

	// one restoring-division step for each counter; the row index is
	// kept modulo the number of store rows as its bits arrive
	always_comb begin
		is_t     = {is_rem_q, is_q[dv_cnt_q]};
		is_ge    = (is_t >= (EWW+1)'(eff_w));
		is_rem_n = is_ge ? EWW'(is_t - (EWW+1)'(eff_w)) : is_t[EWW-1:0];
		is_rm_t  = {is_rm_q, is_ge};
		is_rm_n  = (is_rm_t >= (RW+1)'(ROWS)) ? RW'(is_rm_t - (RW+1)'(ROWS))
		                                      : is_rm_t[RW-1:0];
		og_t     = {og_rem_q, og_q[dv_cnt_q]};
		og_ge    = (og_t >= (EWW+1)'(eff_w));
		og_rem_n = og_ge ? EWW'(og_t - (EWW+1)'(eff_w)) : og_t[EWW-1:0];
		og_rm_t  = {og_rm_q, og_ge};
		og_rm_n  = (og_rm_t >= (RW+1)'(ROWS)) ? RW'(og_rm_t - (RW+1)'(ROWS))
		                                      : og_rm_t[RW-1:0];
		dv_end   = (state_q == ST_RECALC) && (dv_cnt_q == '0) && !cfg_we;
	end

	assign wr_addr = AW'(wrm_b) * AW'(MAX_WIDTH) + AW'(wcol_b);
	assign rd_addr = AW'(grm_q) * AW'(MAX_WIDTH) + AW'(gc_q);
	assign rd_en   = (state_q == ST_GATHER);
	assign fin     = (state_q == ST_EMIT) && (!out_v_q || m_tready);

	mfcw_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (acc && do_wr),
		.wr_addr (wr_addr),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mfcw_rank #(.WIN_MAX(WIN_MAX), .NW(NW)) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.n      (n_q),
		.win    (win_q),
		.stat   (rstat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cfg_we) state_d = ST_RECALC;
				else if (acc && emit) state_d = ST_GATHER;
			end
			ST_GATHER: if (gather_end) state_d = ST_TAIL;
			ST_TAIL:   state_d = ST_START;
			ST_START:  state_d = ST_SELECT;
			ST_SELECT: if (rstat.done) state_d = ST_EMIT;
			ST_EMIT:   if (fin) state_d = ST_IDLE;
			ST_RECALC: if (!cfg_we && dv_cnt_q == '0) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		gather_end = (gc_q == c1_q) && (gr_q == r1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			is_q    <= '0;
			og_q    <= '0;
			wcol_q  <= '0;
			wrm_q   <= '0;
			ocol_q  <= '0;
			orm_q   <= '0;
			orow_q  <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (acc) begin
				// take the restarted frame view, then advance it
				og_q   <= og_b;
				ocol_q <= ocol_b;
				orm_q  <= orm_b;
				orow_q <= orow_b;
				is_q   <= drop ? is_b : is_n;
				if (do_wr && (EWW'(wcol_b) == eff_w - 1'b1)) begin
					wcol_q <= '0;
					wrm_q  <= (wrm_b == RW'(ROWS - 1)) ? '0 : wrm_b + 1'b1;
				end else if (do_wr) begin
					wcol_q <= wcol_b + 1'b1;
					wrm_q  <= wrm_b;
				end else begin
					wcol_q <= wcol_b;
					wrm_q  <= wrm_b;
				end
			end
			if (dv_end) begin
				// positions of both counters under the new width
				wcol_q <= is_rem_n[CW-1:0];
				wrm_q  <= is_rm_n;
				ocol_q <= og_rem_n[CW-1:0];
				orm_q  <= og_rm_n;
				orow_q <= {og_quo_q[11:0], og_ge};
			end
			if (fin) begin
				if (og_q + 1'b1 >= total) begin
					is_q   <= '0;
					og_q   <= '0;
					wcol_q <= '0;
					wrm_q  <= '0;
					ocol_q <= '0;
					orm_q  <= '0;
					orow_q <= '0;
				end else begin
					og_q <= og_q + 1'b1;
					if (EWW'(ocol_q) == eff_w - 1'b1) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
						orm_q  <= (orm_q == RW'(ROWS - 1)) ? '0 : orm_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
			end
			if (fin) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// division walk: restart on every register write
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			dv_cnt_q <= DCW'(CNT_W - 1);
			is_rem_q <= '0;
			og_rem_q <= '0;
			is_rm_q  <= '0;
			og_rm_q  <= '0;
			og_quo_q <= '0;
		end else if (state_q == ST_RECALC) begin
			dv_cnt_q <= dv_cnt_q - 1'b1;
			is_rem_q <= is_rem_n;
			og_rem_q <= og_rem_n;
			is_rm_q  <= is_rm_n;
			og_rm_q  <= og_rm_n;
			og_quo_q <= {og_quo_q[11:0], og_ge};
		end
	end

	// gather walk and window capture
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			gc_q  <= c0_n;
			c0_q  <= c0_n;
			c1_q  <= c1_n;
			gr_q  <= r0_n;
			r1_q  <= r1_n;
			grm_q <= rs_n[RW-1:0];
			n_q   <= '0;
		end else if (rd_en) begin
			if (gc_q == c1_q) begin
				gc_q  <= c0_q;
				gr_q  <= gr_q + 1'b1;
				grm_q <= (grm_q == RW'(ROWS - 1)) ? '0 : grm_q + 1'b1;
			end else begin
				gc_q <= gc_q + 1'b1;
			end
		end
		if (rd_v_s1) begin
			win_q[n_q[WIW-1:0]] <= rd_data;
			n_q <= n_q + 1'b1;
		end
		if (fin) begin
			out_d_q <= rstat.value;
			out_l_q <= (og_q == total - 1'b1);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;

endmodule

FILE: rtl/mfcw_checker.sv
// ----------------------------------------------------------------------------
// mfcw_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mfcw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       cfg_we
);

	// hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	// a new result only follows a busy cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without processing");

	// back to idle as a result is loaded
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready || cfg_we)
		else $error("input not ready after result load");

endmodule

bind median_filter_clipped_window_core mfcw_checker u_mfcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.cfg_we   (cfg_we)
);
